// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked assertion, disabled while reset is low
`define DDE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion checked at every edge
`define DDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDE_ASSERT(lbl, clk, rst_n, prop, msg)
`define DDE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/dde_pkg.sv -----
// ---------------------------------------------------------------------------
// Duffing derivative package
// Payload types, register codes and fixed-point constants of the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dde_pkg;

    // Fixed point format of all fields
    localparam int FRAC_BITS        = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    // Cosine latency apart from the CORDIC steps: product, reduction, fold, output
    localparam int RED_STEPS        = 18;
    localparam int COS_FIXED_LAT    = RED_STEPS + 3;
    localparam int PHASE_BITS       = 52 - FRAC_BITS;

    // 2*pi and its half and quarter, FRAC_BITS fraction bits
    localparam logic [PHASE_BITS-1:0] P2_WIDE    = PHASE_BITS'(411775);
    localparam logic [18:0]           P2         = 19'd411775;
    localparam logic [18:0]           P2_HALF    = 19'd205887;
    localparam logic [18:0]           P2_QUARTER = 19'd102943;
    localparam logic signed [33:0]    CORDIC_K   = 34'sd652032874;

    // Configuration register codes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUBIC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ    = 3'd4;

    typedef struct packed {
        logic        [31:0] time_now;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] external_force;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] velocity_out;
        logic signed [31:0] acceleration;
        logic               overflow;
    } t_out_item;

    // arctan(2^-i) in Q30, rounded to nearest
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0: v = 32'd843314857;
            1: v = 32'd497837829;
            2: v = 32'd263043837;
            3: v = 32'd133525159;
            4: v = 32'd67021687;
            5: v = 32'd33543516;
            6: v = 32'd16775851;
            7: v = 32'd8388437;
            8: v = 32'd4194283;
            9: v = 32'd2097149;
            default: v = (idx < 31) ? (32'd1 << (30 - idx)) : 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/dde_cos.sv -----
// ---------------------------------------------------------------------------
// Duffing derivative cosine pipeline
// Phase product, modulo 2*pi reduction, quadrant fold and CORDIC rotation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dde_cos #(
    parameter int CORDIC_STEPS = dde_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_time_now,
    input  logic [19:0] i_freq,
    output logic [19:0] o_cos_mag,
    output logic        o_cos_neg
);
    import dde_pkg::*;

    localparam int ZSH = 30 - FRAC_BITS;

    logic [51:0]           r_phase_prod;
    logic [PHASE_BITS-1:0] r_red [RED_STEPS];
    logic [18:0]           w_r, w_r1, w_r2;
    logic                  w_neg;
    logic signed [33:0]    r_z;
    logic                  r_neg;
    logic signed [33:0]    r_cx [CORDIC_STEPS];
    logic signed [33:0]    r_cy [CORDIC_STEPS];
    logic signed [33:0]    r_cz [CORDIC_STEPS];
    logic                  r_cneg [CORDIC_STEPS];
    logic signed [33:0]    w_c, w_cmag;

    // Form frequency times time
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phase_prod <= 52'(i_freq) * 52'(i_time_now);
        end
    end

    // Reduce modulo 2*pi: one conditional subtract of a shifted 2*pi per stage
    for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
        localparam logic [PHASE_BITS-1:0] SUB = P2_WIDE << (RED_STEPS - 1 - j);
        logic [PHASE_BITS-1:0] w_src;
        if (j == 0) begin : g_first
            assign w_src = r_phase_prod[51:FRAC_BITS];
        end else begin : g_next
            assign w_src = r_red[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_red[j] <= (w_src >= SUB) ? (w_src - SUB) : w_src;
            end
        end
    end

    // Fold into the first quadrant, note the sign flip
    always_comb begin
        w_r   = r_red[RED_STEPS-1][18:0];
        w_r1  = (w_r > P2_HALF) ? (P2 - w_r) : w_r;
        w_neg = (w_r1 > P2_QUARTER);
        w_r2  = w_neg ? (P2_HALF - w_r1) : w_r1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z   <= $signed(34'({w_r2, ZSH'(0)}));
            r_neg <= w_neg;
        end
    end

    // Rotate: one CORDIC step per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        localparam logic signed [33:0] ATAN = $signed({2'b00, atan_q30(i)});
        logic signed [33:0] w_x, w_y, w_zz;
        logic               w_n;
        if (i == 0) begin : g_first
            assign w_x  = CORDIC_K;
            assign w_y  = '0;
            assign w_zz = r_z;
            assign w_n  = r_neg;
        end else begin : g_next
            assign w_x  = r_cx[i-1];
            assign w_y  = r_cy[i-1];
            assign w_zz = r_cz[i-1];
            assign w_n  = r_cneg[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_zz[33]) begin
                    r_cx[i] <= w_x - (w_y >>> i);
                    r_cy[i] <= w_y + (w_x >>> i);
                    r_cz[i] <= w_zz - ATAN;
                end else begin
                    r_cx[i] <= w_x + (w_y >>> i);
                    r_cy[i] <= w_y - (w_x >>> i);
                    r_cz[i] <= w_zz + ATAN;
                end
                r_cneg[i] <= w_n;
            end
        end
    end

    // Apply the sign, truncate the magnitude to FRAC_BITS fraction bits
    always_comb begin
        w_c    = r_cneg[CORDIC_STEPS-1] ? -r_cx[CORDIC_STEPS-1] : r_cx[CORDIC_STEPS-1];
        w_cmag = w_c[33] ? -w_c : w_c;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos_mag <= w_cmag[ZSH+19:ZSH];
            o_cos_neg <= w_c[33];
        end
    end

endmodule

// ----- rtl/core/duffing_derivative_eval_unit.sv -----
// ---------------------------------------------------------------------------
// Duffing derivative evaluation unit
// Throughput: one request per cycle, set by the fully pipelined cosine path, while the output queue is not full.
// A two-entry output queue keeps taking requests while one result waits.
// Reset clears valid bits and the queue and loads default coefficient values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module duffing_derivative_eval_unit #(
    parameter int CORDIC_STEPS = dde_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  dde_pkg::t_in_item                   i_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output dde_pkg::t_out_item                  o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dde_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dde_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import dde_pkg::*;

    localparam int LC = CORDIC_STEPS + COS_FIXED_LAT;
    localparam int PD = LC - 4;
    localparam logic signed [65:0] ACC_MAX = 66'sd2147483647;
    localparam logic signed [65:0] ACC_MIN = -66'sd2147483648;

    logic signed [19:0] r_linear, r_cubic;
    logic        [18:0] r_damping;
    logic        [19:0] r_amp, r_freq;

    logic        w_en, w_push, w_pop;
    logic        r_vld [LC+1];
    logic [31:0] r_vel [LC+1];

    logic [31:0] w_mx, w_mv;
    logic [19:0] w_ma, w_mb;
    logic [50:0] r1_dprod;
    logic [51:0] r1_aprod;
    logic [63:0] r1_sq;
    logic [31:0] r1_mx;
    logic        r1_sv, r1_sa, r1_sb, r2_sv, r2_sa, r2_sb, r3_sv, r3_sa, r3_sb;
    logic        r4_sv, r4_sa, r4_sb, r5_sv, r5_sa, r5_sb;
    logic signed [31:0] r1_u, r2_u, r3_u, r4_u, r5_u;
    logic [63:0] r2_pl;
    logic [47:0] r2_ph;
    logic [34:0] r2_dm, r3_dm, r4_dm, r5_dm;
    logic [35:0] r2_am, r3_am, r4_am, r5_am;
    logic [79:0] w_x3full;
    logic [61:0] r3_x3;
    logic [51:0] r4_bl;
    logic [49:0] r4_bh;
    logic [81:0] w_bfull;
    logic [65:0] w_bsh;
    logic [62:0] r5_bm;
    logic signed [65:0] w_td, w_ta, w_tb, w_tu, w_tg, w_acc;
    logic signed [65:0] r_pd [PD];
    logic [19:0] w_cos_mag;
    logic        w_cos_neg;
    logic [39:0] r_gm;
    logic        r_gneg;
    t_out_item   w_res;
    t_out_item   r_fifo [2];
    logic        r_wr, r_rd;
    logic [1:0]  r_cnt;

    // Write coefficient registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear  <= 20'shF0000;
            r_cubic   <= 20'sh10000;
            r_damping <= 19'd19661;
            r_amp     <= 20'd24248;
            r_freq    <= 20'd78643;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINEAR:  r_linear  <= $signed(i_cfg_data);
                CFG_CUBIC:   r_cubic   <= $signed(i_cfg_data);
                CFG_DAMPING: r_damping <= i_cfg_data[18:0];
                CFG_AMP:     r_amp     <= i_cfg_data;
                CFG_FREQ:    r_freq    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline while the output queue has room
    assign w_en    = (r_cnt != 2'd2);
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LC; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= LC; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Carry velocity to the output stage
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vel[0] <= i_in.velocity;
            for (int k = 1; k <= LC; k++) r_vel[k] <= r_vel[k-1];
        end
    end

    // Magnitudes of the operands
    always_comb begin
        w_mx = i_in.position[31] ? (~i_in.position + 32'd1) : i_in.position;
        w_mv = i_in.velocity[31] ? (~i_in.velocity + 32'd1) : i_in.velocity;
        w_ma = r_linear[19] ? (~r_linear + 20'd1) : r_linear;
        w_mb = r_cubic[19] ? (~r_cubic + 20'd1) : r_cubic;
    end

    // Polynomial stages: products, cube, stiffness terms, partial sum
    always_comb begin
        w_x3full = {r2_ph, 32'd0} + {16'd0, r2_pl};
        w_bfull  = {r4_bh, 32'd0} + {30'd0, r4_bl};
        w_bsh    = w_bfull[81:FRAC_BITS];
        w_td     = $signed({31'd0, r5_dm});
        w_ta     = $signed({30'd0, r5_am});
        w_tb     = $signed({3'd0, r5_bm});
        w_tu     = 66'(r5_u);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dprod <= 51'(w_mv) * 51'(r_damping);
            r1_aprod <= 52'(w_mx) * 52'(w_ma);
            r1_sq    <= 64'(w_mx) * 64'(w_mx);
            r1_mx    <= w_mx;
            r1_sv    <= i_in.velocity[31];
            r1_sa    <= i_in.position[31] ^ r_linear[19];
            r1_sb    <= i_in.position[31] ^ r_cubic[19];
            r1_u     <= i_in.external_force;

            r2_pl <= 64'(r1_sq[47:16]) * 64'(r1_mx);
            r2_ph <= 48'(r1_sq[63:48]) * 48'(r1_mx);
            r2_dm <= r1_dprod[50:FRAC_BITS];
            r2_am <= r1_aprod[51:FRAC_BITS];
            {r2_sv, r2_sa, r2_sb, r2_u} <= {r1_sv, r1_sa, r1_sb, r1_u};

            r3_x3 <= w_x3full[77:FRAC_BITS];
            {r3_dm, r3_am, r3_sv, r3_sa, r3_sb, r3_u} <=
                {r2_dm, r2_am, r2_sv, r2_sa, r2_sb, r2_u};

            r4_bl <= 52'(r3_x3[31:0]) * 52'(w_mb);
            r4_bh <= 50'(r3_x3[61:32]) * 50'(w_mb);
            {r4_dm, r4_am, r4_sv, r4_sa, r4_sb, r4_u} <=
                {r3_dm, r3_am, r3_sv, r3_sa, r3_sb, r3_u};

            // Clamp the cubic term magnitude at 2^62
            r5_bm <= (w_bsh > {4'd0, 62'd0} + (66'd1 << 62)) ? {1'b1, 62'd0} : w_bsh[62:0];
            {r5_dm, r5_am, r5_sv, r5_sa, r5_sb, r5_u} <=
                {r4_dm, r4_am, r4_sv, r4_sa, r4_sb, r4_u};

            r_pd[0] <= (r5_sv ? w_td : -w_td) + (r5_sa ? w_ta : -w_ta)
                     + (r5_sb ? w_tb : -w_tb) + w_tu;
            for (int k = 1; k < PD; k++) r_pd[k] <= r_pd[k-1];
        end
    end

    // Cosine of the forcing phase
    dde_cos #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cos (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_time_now (i_in.time_now),
        .i_freq     (r_freq),
        .o_cos_mag  (w_cos_mag),
        .o_cos_neg  (w_cos_neg)
    );

    // Scale the cosine by the forcing amplitude
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gm   <= 40'(w_cos_mag) * 40'(r_amp);
            r_gneg <= w_cos_neg;
        end
    end

    // Sum and saturate
    always_comb begin
        w_tg  = $signed({42'd0, r_gm[39:FRAC_BITS]});
        w_acc = r_pd[PD-1] + (r_gneg ? -w_tg : w_tg);
        w_res.velocity_out = r_vel[LC];
        if (w_acc > ACC_MAX) begin
            w_res.acceleration = 32'sh7FFFFFFF;
            w_res.overflow     = 1'b1;
        end else if (w_acc < ACC_MIN) begin
            w_res.acceleration = 32'sh80000000;
            w_res.overflow     = 1'b1;
        end else begin
            w_res.acceleration = w_acc[31:0];
            w_res.overflow     = 1'b0;
        end
    end

    // Output queue: push finished requests, pop on handshake
    assign w_push  = w_en && r_vld[LC];
    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_out   = r_fifo[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `DDE_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "output queue count out of range")
    `DDE_ASSERT(a_full_stall, i_clk, i_rst_n, (r_cnt == 2'd2) |-> !o_ready, "ready while queue full")
    `DDE_ASSERT(a_accept_enters, i_clk, i_rst_n, (i_valid && o_ready) |=> r_vld[0], "accepted request lost")
    `DDE_ASSERT(a_stall_holds, i_clk, i_rst_n, !w_en |=> $stable(r_vld[LC]), "stalled result moved")

endmodule

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// Duffing derivative evaluation unit testbench
// Streams derivative requests through the unit under several coefficient
// settings. Predicts each result in-line with its own fixed-point model,
// then checks every returned result against the oldest pending one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import dde_pkg::*;

    localparam int IDLE_PCT = 21;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam longint ARCTAN_Q30 [0:15] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768
    };
    localparam logic [63:0] MAG_LIMIT = 64'd1 << 62;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    t_in_item i_in;
    t_out_item o_out;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Coefficient copy kept in step with the unit
    logic signed [19:0] coef_linear, coef_cubic;
    logic [18:0] coef_damping;
    logic [19:0] coef_amp, coef_freq;

    t_out_item pending_results[$];
    int mismatches = 0;
    int quiet_cycles;
    bit steady;

    duffing_derivative_eval_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_in(i_in),
        .o_valid(o_valid), .i_ready(i_ready), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Scaled magnitude product, truncated and clamped at 2^62
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [31:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {96'd0, b};
        p = p >> FRAC_BITS;
        if (p > {64'd0, MAG_LIMIT}) return MAG_LIMIT;
        return p[63:0];
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Cosine in Q30 of a phase folded into the first quadrant
    function automatic longint forcing_cosine(logic [63:0] phase);
        logic [63:0] r;
        bit neg;
        longint cx, cy, cz, nx;
        neg = 1'b0;
        r = phase % 64'(P2);
        if (r > 64'(P2_HALF)) r = 64'(P2) - r;
        if (r > 64'(P2_QUARTER)) begin
            r = 64'(P2_HALF) - r;
            neg = 1'b1;
        end
        cz = longint'(r << (30 - FRAC_BITS));
        cx = longint'(CORDIC_K);
        cy = 0;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            if (cz >= 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cz = cz - ARCTAN_Q30[i];
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cz = cz + ARCTAN_Q30[i];
            end
            cx = nx;
        end
        return neg ? -cx : cx;
    endfunction

    // Derivative of the forced oscillator for one request
    function automatic t_out_item duffing_derivative(t_in_item req);
        t_out_item res;
        longint x, v, u, alpha, beta, cval, dterm, aterm, bterm, gterm, acc;
        logic [63:0] mx, x2, x3, phase, cm;
        x = longint'(req.position);
        v = longint'(req.velocity);
        u = longint'(req.external_force);
        alpha = longint'(coef_linear);
        beta = longint'(coef_cubic);
        mx = magnitude(x);
        dterm = longint'(scaled_product(magnitude(v), 32'(coef_damping)));
        if (v < 0) dterm = -dterm;
        aterm = longint'(scaled_product(mx, 32'(magnitude(alpha))));
        if ((x < 0) != (alpha < 0)) aterm = -aterm;
        x2 = scaled_product(mx, mx[31:0]);
        x3 = scaled_product(x2, mx[31:0]);
        bterm = longint'(scaled_product(x3, 32'(magnitude(beta))));
        if ((x < 0) != (beta < 0)) bterm = -bterm;
        phase = (64'(coef_freq) * 64'(req.time_now)) >> FRAC_BITS;
        cval = forcing_cosine(phase);
        cm = magnitude(cval) >> (30 - FRAC_BITS);
        gterm = longint'(scaled_product(cm, 32'(coef_amp)));
        if (cval < 0) gterm = -gterm;
        acc = -dterm - aterm - bterm + gterm + u;
        res.overflow = 1'b0;
        if (acc > 64'sd2147483647) begin
            acc = 64'sd2147483647;
            res.overflow = 1'b1;
        end else if (acc < -64'sd2147483648) begin
            acc = -64'sd2147483648;
            res.overflow = 1'b1;
        end
        res.velocity_out = req.velocity;
        res.acceleration = acc[31:0];
        return res;
    endfunction

    // Receiver stalls, plus result check and watchdog
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", o_out);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out.velocity_out !== want.velocity_out
                        || o_out.acceleration !== want.acceleration
                        || o_out.overflow !== want.overflow) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp v=%h a=%h ovf=%b got v=%h a=%h ovf=%b",
                                     want.velocity_out, want.acceleration, want.overflow,
                                     o_out.velocity_out, o_out.acceleration, o_out.overflow);
                    end
                end
            end
        end
    end

    // Send one request, with an occasional gap ahead of it
    task automatic send_request(input t_in_item req);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= req;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(duffing_derivative(req));
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_LINEAR:  coef_linear = val;
            CFG_CUBIC:   coef_cubic = val;
            CFG_DAMPING: coef_damping = val[18:0];
            CFG_AMP:     coef_amp = val;
            CFG_FREQ:    coef_freq = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input int lin, input int cub, input int damp,
                             input int amp, input int freq);
        wait_drain();
        write_coef(CFG_LINEAR, 20'(lin));
        write_coef(CFG_CUBIC, 20'(cub));
        write_coef(CFG_DAMPING, 20'(damp));
        write_coef(CFG_AMP, 20'(amp));
        write_coef(CFG_FREQ, 20'(freq));
    endtask

    // Mix of full-range, moderate and extreme Q16.16 values
    function automatic logic [31:0] random_q();
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2: return 32'($urandom_range(0, 524288)) - 32'd262144;
            3: return 32'($urandom_range(0, 4096)) - 32'd2048;
            4: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($urandom_range(0, 33554432)) - 32'd16777216;
        endcase
    endfunction

    function automatic t_in_item random_request();
        t_in_item req;
        req.time_now = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 2000000));
        req.position = random_q();
        req.velocity = random_q();
        req.external_force = $urandom_range(0, 3) == 0 ? 32'd0 : random_q();
        return req;
    endfunction

    function automatic t_in_item make_request(logic [31:0] t, logic [31:0] x,
                                              logic [31:0] v, logic [31:0] u);
        t_in_item req;
        req.time_now = t;
        req.position = x;
        req.velocity = v;
        req.external_force = u;
        return req;
    endfunction

    // Field extremes, saturation both ways and every phase quadrant
    task automatic test_directed();
        send_request(make_request(0, 0, 0, 0));
        send_request(make_request(32'hffff_ffff, 0, 0, 0));
        send_request(make_request(0, 32'h7fff_ffff, 0, 0));
        send_request(make_request(0, 32'h8000_0000, 0, 0));
        send_request(make_request(0, 0, 32'h7fff_ffff, 0));
        send_request(make_request(0, 0, 32'h8000_0000, 0));
        send_request(make_request(0, 0, 0, 32'h7fff_ffff));
        send_request(make_request(0, 0, 0, 32'h8000_0000));
        send_request(make_request(0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_request(make_request(0, 32'hffff_0000, 32'hffff_0000, 32'hffff_0000));
        send_request(make_request(0, 32'h0020_0000, 0, 0));
        send_request(make_request(0, 32'hffe0_0000, 0, 0));
        send_request(make_request(32'h0000_8000, 0, 0, 0));
        send_request(make_request(32'h0001_0000, 0, 0, 0));
        send_request(make_request(32'h0002_0000, 0, 0, 0));
        send_request(make_request(32'h0003_0000, 0, 0, 0));
        send_request(make_request(32'h0004_0000, 0, 0, 0));
        send_request(make_request(32'h0005_0000, 0, 0, 0));
        send_request(make_request(32'h0001_4f1a, 32'h0000_0001, 32'hffff_ffff, 1));
        send_request(make_request(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff));
    endtask

    // Coefficient extremes, each followed by a burst of random requests
    task automatic test_coef_sweep();
        write_all(-327680, -327680, 0, 0, 655);
        repeat (60) send_request(random_request());
        write_all(327680, 327680, 327680, 655360, 655360);
        repeat (60) send_request(random_request());
        write_all(0, 0, 0, 655360, 78643);
        repeat (60) send_request(random_request());
        write_all(-65536, 65536, 19661, 24248, 78643);
        repeat (60) send_request(random_request());
    endtask

    // Back-to-back requests with no stalls on either side
    task automatic test_full_rate();
        steady = 1'b1;
        repeat (200) send_request(random_request());
        steady = 1'b0;
    endtask

    // Hold the sender until every pending result is back, then resume
    task automatic test_pause_drain();
        repeat (40) send_request(random_request());
        wait_drain();
        repeat (40) send_request(random_request());
    endtask

    task automatic test_random();
        for (int k = 0; k < 600; k++) begin
            if (k % 150 == 0)
                write_all(int'($urandom_range(0, 655360)) - 327680,
                          int'($urandom_range(0, 655360)) - 327680,
                          $urandom_range(0, 327680), $urandom_range(0, 655360),
                          $urandom_range(655, 655360));
            send_request(random_request());
        end
    endtask

    initial begin
        steady = 1'b0;
        coef_linear = -20'sd65536;
        coef_cubic = 20'sd65536;
        coef_damping = 19'd19661;
        coef_amp = 20'd24248;
        coef_freq = 20'd78643;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_coef_sweep();
        test_full_rate();
        test_pause_drain();
        test_random();

        wait_drain();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/dde_pkg.sv
rtl/core/dde_cos.sv
rtl/core/duffing_derivative_eval_unit.sv
tb/tb_top.sv
